// ===== hw/rtl/swap_block_bitmap_allocator_assert.svh =====
// Assertion macros used by the checker of the allocator.
// Each expects signals named clk and arst_n in the scope where it is used.
`ifndef SWAP_BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH
`define SWAP_BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SBBA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SBBA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/sbba_pkg.sv =====
package sbba_pkg;

	localparam int MAP_BYTES  = 512;
	localparam int MAP_BLOCKS = MAP_BYTES * 8;
	localparam int BLOCK_SPAN = 4096;
	localparam int LIMIT_CAP  = (MAP_BLOCKS < BLOCK_SPAN) ? MAP_BLOCKS : BLOCK_SPAN;

	localparam int ADDR_W  = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
	localparam int BLOCK_W = 12;
	localparam int POOL_W  = 13;
	localparam int CMP_W   = ((ADDR_W + 4) > POOL_W) ? (ADDR_W + 4) : POOL_W;

	localparam logic [POOL_W-1:0] POOL_RESET = POOL_W'(100);

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FREE
	} sbba_state_t;

endpackage

// ===== hw/rtl/sbba_cfg_if.sv =====
interface sbba_cfg_if import sbba_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [POOL_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/sbba_req_if.sv =====
interface sbba_req_if import sbba_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               kind;
	logic [BLOCK_W-1:0] block;

	modport source (output valid, output kind, output block, input ready);
	modport sink (input valid, input kind, input block, output ready);
endinterface

// ===== hw/rtl/sbba_rsp_if.sv =====
interface sbba_rsp_if import sbba_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               granted;
	logic [BLOCK_W-1:0] block_out;

	modport source (output valid, output granted, output block_out, input ready);
	modport sink (input valid, input granted, input block_out, output ready);
endinterface

// ===== hw/rtl/swap_block_bitmap_allocator.sv =====
// First-fit swap block allocator over a byte-wide bitmap memory.
// Channels: req carries kind (allocate or free) and block; rsp returns granted and
// block_out, one result per request; cfg writes pool_size and is always ready.
// Only one request is in flight: req.ready is high while the block is idle.
// An allocate reads byte 0 on acceptance; in ST_SCAN it then passes each completely
// full byte, one byte a cycle through the bitmap RAM's single read port, and loads
// its result at the first byte with a clear bit or past the pool size. A full
// 4096-block pool scans at most 512 bytes. A free reads its byte on acceptance,
// then in ST_FREE loads its result and writes the byte back once the output
// register is free. The next request is taken from the cycle after the load.
// The result sits in an output register, so a new request is taken while an
// earlier result still waits; if rsp stalls, a finished scan holds in place until
// the register frees up, and the bitmap is not written until then.
// After reset the bitmap RAM is cleared one byte a cycle, with block 0 marked used;
// req.ready stays low during this pass. cfg writes are accepted throughout.
// pool_size resets to 100.
module swap_block_bitmap_allocator import sbba_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	sbba_cfg_if.sink   cfg,
	sbba_req_if.sink   req,
	sbba_rsp_if.source rsp
);

	logic [7:0]         mem [MAP_BYTES];
	logic [7:0]         rd_data_q;
	logic [ADDR_W-1:0]  rd_addr;
	logic               rd_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [7:0]         wr_data;
	logic               wr_en;

	sbba_state_t        state_q, state_d;
	logic [ADDR_W-1:0]  clr_addr_q;
	logic [ADDR_W:0]    byte_q, byte_d;
	logic [POOL_W-1:0]  pool_q;
	logic [POOL_W-1:0]  limit_q, limit_d;
	logic [BLOCK_W-1:0] free_blk_q;
	logic               free_ok_q, free_ok_d;

	logic               rsp_valid_q;
	logic               rsp_granted_q;
	logic [BLOCK_W-1:0] rsp_block_q;
	logic               rsp_load;
	logic               rsp_granted_d;
	logic [BLOCK_W-1:0] rsp_block_d;
	logic               out_free;
	logic               req_fire;

	logic [3:0]         clear_bit;
	logic [CMP_W-1:0]   scan_base;
	logic [CMP_W-1:0]   cand;
	logic               past_limit;

	// Lowest clear bit of a byte: {found, index}.
	function automatic logic [3:0] first_clear(input logic [7:0] b);
		logic [3:0] r;
		r = 4'b0000;
		for (int j = 7; j >= 0; j--) begin
			if (!b[j]) begin
				r = {1'b1, 3'(j)};
			end
		end
		return r;
	endfunction

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign out_free  = !rsp_valid_q || rsp.ready;

	assign rsp.valid     = rsp_valid_q;
	assign rsp.granted   = rsp_granted_q;
	assign rsp.block_out = rsp_block_q;

	assign clear_bit  = first_clear(rd_data_q);
	assign scan_base  = CMP_W'(byte_q) << 3;
	assign cand       = scan_base | CMP_W'(clear_bit[2:0]);
	assign past_limit = scan_base >= CMP_W'(limit_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_comb begin
		state_d       = state_q;
		byte_d        = byte_q;
		limit_d       = limit_q;
		free_ok_d     = free_ok_q;
		rd_addr       = '0;
		rd_en         = 1'b0;
		wr_addr       = '0;
		wr_data       = '0;
		wr_en         = 1'b0;
		rsp_load      = 1'b0;
		rsp_granted_d = 1'b0;
		rsp_block_d   = '0;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_addr_q;
				wr_data = (clr_addr_q == '0) ? 8'h01 : 8'h00;
				if (clr_addr_q == ADDR_W'(MAP_BYTES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_fire) begin
					rd_en = 1'b1;
					if (req.kind == KIND_ALLOC) begin
						rd_addr = '0;
						byte_d  = '0;
						limit_d = (pool_q > POOL_W'(LIMIT_CAP)) ? POOL_W'(LIMIT_CAP) : pool_q;
						state_d = ST_SCAN;
					end else begin
						rd_addr   = ADDR_W'(req.block >> 3);
						free_ok_d = (req.block != '0) &&
							(CMP_W'(req.block) < CMP_W'(MAP_BLOCKS));
						state_d   = ST_FREE;
					end
				end
			end
			ST_SCAN: begin
				if (past_limit) begin
					if (out_free) begin
						rsp_load = 1'b1;
						state_d  = ST_IDLE;
					end
				end else if (!clear_bit[3]) begin
					// full byte: advance to the next one
					byte_d  = byte_q + 1'b1;
					rd_addr = ADDR_W'(byte_q + 1'b1);
					rd_en   = 1'b1;
				end else if (out_free) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
					if (cand < CMP_W'(limit_q)) begin
						wr_en         = 1'b1;
						wr_addr       = ADDR_W'(byte_q);
						wr_data       = rd_data_q | (8'h01 << clear_bit[2:0]);
						rsp_granted_d = 1'b1;
						rsp_block_d   = BLOCK_W'(cand);
					end
				end
			end
			ST_FREE: begin
				if (out_free) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
					if (free_ok_q) begin
						wr_en   = 1'b1;
						wr_addr = ADDR_W'(free_blk_q >> 3);
						wr_data = rd_data_q & ~(8'h01 << free_blk_q[2:0]);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			byte_q      <= '0;
			pool_q      <= POOL_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			byte_q  <= byte_d;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (cfg.valid && cfg.ready) begin
				pool_q <= cfg.data;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		limit_q   <= limit_d;
		free_ok_q <= free_ok_d;
		if (req_fire) begin
			free_blk_q <= req.block;
		end
		if (rsp_load) begin
			rsp_granted_q <= rsp_granted_d;
			rsp_block_q   <= rsp_block_d;
		end
	end

endmodule

// ===== hw/rtl/sbba_checker.sv =====
`include "swap_block_bitmap_allocator_assert.svh"

module sbba_checker import sbba_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic               granted,
	input logic [BLOCK_W-1:0] block_out
);

	// a stalled result transaction holds its payload
	`SBBA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(granted) && $stable(block_out), "rsp payload changed while stalled")

	`SBBA_ASSERT_NOW(a_nogrant_zero, rsp_valid && !granted, block_out == '0, "block_out nonzero without grant")

	// block 0 is reserved and never handed out
	`SBBA_ASSERT_NOW(a_grant_nonzero, rsp_valid && granted, block_out != '0, "reserved block 0 granted")

	// one request in flight: ready drops after each accepted transaction
	`SBBA_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "request accepted while busy")

endmodule

bind swap_block_bitmap_allocator sbba_checker u_sbba_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.granted   (rsp.granted),
	.block_out (rsp.block_out)
);
